/* design/mthw_pkg.sv */
// Shared types and constants for the multi-task heartbeat watchdog.
`timescale 1ns / 1ps
`default_nettype none
package mthw_pkg;

	localparam int NUM_SLOTS_DEF = 16;
	localparam logic [31:0] DEFAULT_PERIOD_RESET = 32'd60000;

	localparam logic [1:0] OP_TICK      = 2'd0;
	localparam logic [1:0] OP_REGISTER  = 2'd1;
	localparam logic [1:0] OP_HEARTBEAT = 2'd2;
	localparam logic [1:0] OP_CHECK     = 2'd3;

	typedef struct packed {
		logic [7:0]  key;
		logic [31:0] last_beat;
		logic [31:0] period;
	} slot_t;

	typedef struct packed {
		logic        key_hit;
		logic        over;
		logic [31:0] age;
	} cmp_t;

endpackage
`default_nettype wire

/* design/mthw_if.sv */
// Channel interfaces: item input, result output and configuration write.
`timescale 1ns / 1ps
`default_nettype none
interface mthw_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [7:0]  task_key;
	logic [31:0] max_period_ms;

	modport source (output valid, output opcode, output task_key, output max_period_ms,
		input ready);
	modport sink (input valid, input opcode, input task_key, input max_period_ms,
		output ready);
endinterface

interface mthw_result_if;
	logic        valid;
	logic        ready;
	logic        table_full;
	logic        frozen_found;
	logic [7:0]  frozen_key;
	logic [31:0] frozen_age_ms;
	logic [31:0] uptime_ms;

	modport source (output valid, output table_full, output frozen_found,
		output frozen_key, output frozen_age_ms, output uptime_ms, input ready);
	modport sink (input valid, input table_full, input frozen_found,
		input frozen_key, input frozen_age_ms, input uptime_ms, output ready);
endinterface

interface mthw_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/multi_task_heartbeat_watchdog_core.sv */
// Top level: sequencer, slot counter, clock counter and result register.
//
//  channel  | dir | beat carries
//  ---------+-----+---------------------------------------------------
//  item     | in  | opcode, task_key, max_period_ms
//  result   | out | table_full, frozen_found, frozen_key, frozen_age_ms, uptime_ms
//  cfg      | in  | default_period_ms
//
//  Tick and register pass from accept through the EXEC and FIN states to result valid.
//  Heartbeat and check scan slots through one memory read port and one compare
//  unit, one slot per cycle, and stop at the first hit.
//  item.ready is high only while the sequencer is idle; a stalled result
//  holds in the output register while the next item is accepted.
//  Reset clears the clock counter and slot count and loads the default period (60000).
`timescale 1ns / 1ps
`default_nettype none
module multi_task_heartbeat_watchdog_core import mthw_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	mthw_item_if.sink     item,
	mthw_result_if.source result,
	mthw_cfg_if.sink      cfg
);

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam logic [CW-1:0] SLOTS_MAX = CW'(NUM_SLOTS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]    state_q;
	logic [1:0]    op_q;
	logic [7:0]    key_q;
	logic [31:0]   per_q;
	logic [31:0]   time_q;
	logic [31:0]   dflt_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] issue_q;
	logic          pend_q;
	logic [IW-1:0] cidx_q;

	logic          r_full_q;
	logic          r_found_q;
	logic [7:0]    r_key_q;
	logic [31:0]   r_age_q;

	logic          res_v_q;
	logic          res_full_q;
	logic          res_found_q;
	logic [7:0]    res_key_q;
	logic [31:0]   res_age_q;
	logic [31:0]   res_up_q;

	slot_t         rd_entry;
	cmp_t          cmp;
	logic          wr_en;
	logic [IW-1:0] wr_idx;
	slot_t         wr_entry;

	logic          accept;
	logic          out_free;
	logic          is_full;
	logic          more;
	logic          hit_now;
	logic          miss_now;
	logic          append;

	mthw_slot_mem #(.NUM_SLOTS(NUM_SLOTS)) u_mem (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_idx   (wr_idx),
		.wr_entry (wr_entry),
		.rd_idx   (issue_q[IW-1:0]),
		.rd_entry (rd_entry)
	);

	mthw_cmp u_cmp (
		.entry (rd_entry),
		.key   (key_q),
		.now   (time_q),
		.res   (cmp)
	);

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign cfg.ready  = 1'b1;
	assign out_free   = !res_v_q || result.ready;
	assign is_full    = (cnt_q == SLOTS_MAX);
	assign more       = (issue_q < cnt_q);
	assign hit_now    = (state_q == ST_SCAN) && pend_q &&
		((op_q == OP_HEARTBEAT) ? cmp.key_hit : cmp.over);
	assign miss_now   = (state_q == ST_SCAN) && !pend_q && !more;

	always_comb begin
		wr_en    = 1'b0;
		wr_idx   = cnt_q[IW-1:0];
		wr_entry = '{key: key_q, last_beat: time_q, period: per_q};
		append   = 1'b0;
		if (state_q == ST_EXEC && op_q == OP_REGISTER && !is_full) begin
			wr_en  = 1'b1;
			append = 1'b1;
		end else if (hit_now && op_q == OP_HEARTBEAT) begin
			wr_en    = 1'b1;
			wr_idx   = cidx_q;
			wr_entry = '{key: rd_entry.key, last_beat: time_q, period: rd_entry.period};
		end else if (miss_now && op_q == OP_HEARTBEAT && !is_full) begin
			wr_en    = 1'b1;
			append   = 1'b1;
			wr_entry = '{key: key_q, last_beat: time_q, period: dflt_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			time_q  <= '0;
			cnt_q   <= '0;
			dflt_q  <= DEFAULT_PERIOD_RESET;
			res_v_q <= 1'b0;
			issue_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				dflt_q <= cfg.data;
			end
			if (append) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == ST_FIN && out_free) begin
				res_v_q <= 1'b1;
			end else if (result.ready) begin
				res_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					issue_q <= '0;
					pend_q  <= 1'b0;
					if (accept) begin
						if (item.opcode == OP_TICK || item.opcode == OP_REGISTER) begin
							state_q <= ST_EXEC;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_EXEC: begin
					if (op_q == OP_TICK) begin
						time_q <= time_q + 32'd1;
					end
					state_q <= ST_FIN;
				end
				ST_SCAN: begin
					pend_q <= more;
					if (more) begin
						issue_q <= issue_q + 1'b1;
					end
					if (hit_now || miss_now) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= item.opcode;
			key_q <= item.task_key;
			per_q <= item.max_period_ms;
		end
		cidx_q <= issue_q[IW-1:0];
		if (state_q == ST_EXEC) begin
			r_full_q  <= (op_q == OP_REGISTER) && is_full;
			r_found_q <= 1'b0;
			r_key_q   <= '0;
			r_age_q   <= '0;
		end else if (hit_now) begin
			r_full_q  <= 1'b0;
			r_found_q <= (op_q == OP_CHECK);
			r_key_q   <= (op_q == OP_CHECK) ? rd_entry.key : 8'd0;
			r_age_q   <= (op_q == OP_CHECK) ? cmp.age : 32'd0;
		end else if (miss_now) begin
			r_full_q  <= (op_q == OP_HEARTBEAT) && is_full;
			r_found_q <= 1'b0;
			r_key_q   <= '0;
			r_age_q   <= '0;
		end
		if (state_q == ST_FIN && out_free) begin
			res_full_q  <= r_full_q;
			res_found_q <= r_found_q;
			res_key_q   <= r_key_q;
			res_age_q   <= r_age_q;
			res_up_q    <= time_q;
		end
	end

	assign result.valid         = res_v_q;
	assign result.table_full    = res_full_q;
	assign result.frozen_found  = res_found_q;
	assign result.frozen_key    = res_key_q;
	assign result.frozen_age_ms = res_age_q;
	assign result.uptime_ms     = res_up_q;

endmodule
`default_nettype wire

/* design/mthw_slot_mem.sv */
// Slot table memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module mthw_slot_mem import mthw_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF,
	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [IW-1:0] wr_idx,
	input  wire slot_t         wr_entry,
	input  wire logic [IW-1:0] rd_idx,
	output slot_t              rd_entry
);

	slot_t mem_q [NUM_SLOTS];
	slot_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= wr_entry;
		end
		rd_q <= mem_q[rd_idx];
	end

	assign rd_entry = rd_q;

endmodule
`default_nettype wire

/* design/mthw_cmp.sv */
// Shared compare unit: key match and wrapped age against period.
`timescale 1ns / 1ps
`default_nettype none
module mthw_cmp import mthw_pkg::*; (
	input  wire slot_t       entry,
	input  wire logic [7:0]  key,
	input  wire logic [31:0] now,
	output cmp_t             res
);

	logic [31:0] age;

	assign age         = now - entry.last_beat;
	assign res.age     = age;
	assign res.over    = age > entry.period;
	assign res.key_hit = entry.key == key;

endmodule
`default_nettype wire

/* tb/tb_multi_task_heartbeat_watchdog_core.sv */
// Self-checking testbench for the multi-task heartbeat watchdog core.
`timescale 1ns / 1ps
module tb_multi_task_heartbeat_watchdog_core;
	import mthw_pkg::*;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  task_key;
		logic [31:0] max_period_ms;
	} watch_item_t;

	typedef struct packed {
		logic        table_full;
		logic        frozen_found;
		logic [7:0]  frozen_key;
		logic [31:0] frozen_age_ms;
		logic [31:0] uptime_ms;
	} watch_status_t;

	logic clk = 1'b0;
	logic arst_n;

	mthw_item_if   item_ch();
	mthw_result_if res_ch();
	mthw_cfg_if    cfg_ch();

	multi_task_heartbeat_watchdog_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	always #5 clk = ~clk;

	logic [31:0]   clock_ms = '0;
	logic [31:0]   auto_period = DEFAULT_PERIOD_RESET;
	int unsigned   used_slots = 0;
	logic [7:0]    slot_key_tbl [NUM_SLOTS_DEF];
	logic [31:0]   slot_beat_tbl [NUM_SLOTS_DEF];
	logic [31:0]   slot_period_tbl [NUM_SLOTS_DEF];

	watch_item_t   item_backlog [$];
	watch_status_t status_q [$];
	logic [7:0]    known_keys [$];
	int            items_queued = 0;
	int            items_accepted = 0;
	int            mismatch_count = 0;
	int            send_idle_pct = 37;
	int            recv_idle_pct = 46;
	logic          item_taken = 1'b0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (mismatch_count < 50)
			$display("%0t ns mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got,
				want);
		mismatch_count++;
	endtask

	function automatic bit append_slot(input logic [7:0] key, input logic [31:0] period);
		if (used_slots >= NUM_SLOTS_DEF)
			return 1'b0;
		slot_key_tbl[used_slots] = key;
		slot_beat_tbl[used_slots] = clock_ms;
		slot_period_tbl[used_slots] = period;
		used_slots++;
		return 1'b1;
	endfunction

	function automatic watch_status_t apply_watch_item(input watch_item_t it);
		watch_status_t st;
		int hit;
		logic [31:0] age;
		st = '0;
		hit = -1;
		case (it.opcode)
			OP_TICK: begin
				clock_ms = clock_ms + 32'd1;
			end
			OP_REGISTER: begin
				if (!append_slot(it.task_key, it.max_period_ms))
					st.table_full = 1'b1;
			end
			OP_HEARTBEAT: begin
				for (int i = 0; i < used_slots; i++)
					if (hit < 0 && slot_key_tbl[i] == it.task_key)
						hit = i;
				if (hit >= 0)
					slot_beat_tbl[hit] = clock_ms;
				else if (!append_slot(it.task_key, auto_period))
					st.table_full = 1'b1;
			end
			default: begin
				for (int i = 0; i < used_slots; i++) begin
					age = clock_ms - slot_beat_tbl[i];
					if (!st.frozen_found && age > slot_period_tbl[i]) begin
						st.frozen_found = 1'b1;
						st.frozen_key = slot_key_tbl[i];
						st.frozen_age_ms = age;
					end
				end
			end
		endcase
		st.uptime_ms = clock_ms;
		return st;
	endfunction

	task automatic queue_item(input logic [1:0] op, input logic [7:0] key,
		input logic [31:0] period);
		watch_item_t it;
		it.opcode = op;
		it.task_key = key;
		it.max_period_ms = period;
		item_backlog.push_back(it);
		items_queued++;
	endtask

	task automatic queue_random_item();
		logic [1:0] op;
		logic [7:0] key;
		logic [31:0] period;
		int unsigned roll;
		key = $urandom_range(0, 255);
		period = $urandom();
		roll = $urandom_range(0, 99);
		if (roll < 40)
			op = OP_TICK;
		else if (roll < 45)
			op = OP_REGISTER;
		else if (roll < 75)
			op = OP_HEARTBEAT;
		else
			op = OP_CHECK;
		if (op == OP_REGISTER || op == OP_HEARTBEAT) begin
			if (known_keys.size() > 0 && $urandom_range(0, 99) < 88)
				key = known_keys[$urandom_range(0, known_keys.size() - 1)];
			known_keys.push_back(key);
		end
		if (op == OP_REGISTER) begin
			roll = $urandom_range(0, 99);
			if (roll < 60)
				period = $urandom_range(0, 40);
			else if (roll < 70)
				period = '0;
			else if (roll < 80)
				period = '1;
		end
		queue_item(op, key, period);
	endtask

	task automatic wait_drained();
		while (items_accepted != items_queued || status_q.size() != 0)
			@(posedge clk);
		repeat (NUM_SLOTS_DEF + 8) @(posedge clk);
	endtask

	task automatic write_default_period(input logic [31:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		auto_period = value;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	always @(negedge clk) begin : item_driver
		watch_item_t next_item;
		if (arst_n && (!item_ch.valid || item_taken)) begin
			item_taken = 1'b0;
			if (item_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				next_item = item_backlog.pop_front();
				item_ch.valid <= 1'b1;
				item_ch.opcode <= next_item.opcode;
				item_ch.task_key <= next_item.task_key;
				item_ch.max_period_ms <= next_item.max_period_ms;
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk)
		res_ch.ready <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);

	always @(posedge clk) begin : beat_monitor
		watch_item_t   seen_item;
		watch_status_t want;
		if (arst_n && item_ch.valid && item_ch.ready) begin
			seen_item.opcode = item_ch.opcode;
			seen_item.task_key = item_ch.task_key;
			seen_item.max_period_ms = item_ch.max_period_ms;
			status_q.push_back(apply_watch_item(seen_item));
			items_accepted++;
			item_taken = 1'b1;
		end
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (status_q.size() == 0) begin
				report_mismatch("result beat with nothing pending", 32'd1, 32'd0);
			end else begin
				want = status_q.pop_front();
				if (res_ch.table_full !== want.table_full)
					report_mismatch("table_full", res_ch.table_full, want.table_full);
				if (res_ch.frozen_found !== want.frozen_found)
					report_mismatch("frozen_found", res_ch.frozen_found, want.frozen_found);
				if (res_ch.frozen_key !== want.frozen_key)
					report_mismatch("frozen_key", res_ch.frozen_key, want.frozen_key);
				if (res_ch.frozen_age_ms !== want.frozen_age_ms)
					report_mismatch("frozen_age_ms", res_ch.frozen_age_ms, want.frozen_age_ms);
				if (res_ch.uptime_ms !== want.uptime_ms)
					report_mismatch("uptime_ms", res_ch.uptime_ms, want.uptime_ms);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.opcode = OP_TICK;
		item_ch.task_key = '0;
		item_ch.max_period_ms = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	initial begin : stimulus
		logic [31:0] period_plan [8];
		period_plan = '{32'd7, 32'hFFFF_FFFF, 32'd0, 32'd3, $urandom(), 32'd1,
			DEFAULT_PERIOD_RESET, $urandom_range(0, 50)};
		wait (arst_n === 1'b1);

		queue_item(OP_CHECK, 8'h00, 32'h0000_0000);
		queue_item(OP_TICK, 8'hFF, 32'hFFFF_FFFF);
		queue_item(OP_HEARTBEAT, 8'hA5, 32'h5A5A_5A5A);
		queue_item(OP_REGISTER, 8'h00, 32'h0000_0000);
		queue_item(OP_REGISTER, 8'hFF, 32'hFFFF_FFFF);
		queue_item(OP_REGISTER, 8'h00, 32'd2);
		queue_item(OP_CHECK, 8'h5A, 32'hA5A5_A5A5);
		queue_item(OP_TICK, 8'h00, 32'h0000_0000);
		queue_item(OP_CHECK, 8'hFF, 32'hFFFF_FFFF);
		queue_item(OP_HEARTBEAT, 8'h00, 32'hFFFF_FFFF);
		queue_item(OP_CHECK, 8'h00, 32'h0000_0000);
		queue_item(OP_TICK, 8'h00, 32'h0000_0000);
		queue_item(OP_TICK, 8'h00, 32'h0000_0000);
		queue_item(OP_CHECK, 8'h00, 32'h0000_0000);
		queue_item(OP_HEARTBEAT, 8'hFF, 32'h0000_0000);
		known_keys = '{8'hA5, 8'h00, 8'hFF, 8'h3C};
		wait_drained();
		write_default_period(32'd0);

		queue_item(OP_HEARTBEAT, 8'h3C, 32'h0000_0000);
		queue_item(OP_TICK, 8'h00, 32'h0000_0000);
		queue_item(OP_CHECK, 8'h00, 32'h0000_0000);
		queue_item(OP_HEARTBEAT, 8'h00, 32'h0000_0000);
		queue_item(OP_CHECK, 8'h00, 32'h0000_0000);
		wait_drained();

		for (int phase = 0; phase < 8; phase++) begin
			write_default_period(period_plan[phase]);
			if (phase == 3) begin
				send_idle_pct = 46;
				recv_idle_pct = 37;
			end else if (phase == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			repeat (100) queue_random_item();
			wait_drained();
		end

		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#5ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
